[rtl/core/cah_pkg.sv]
package cah_pkg;

   localparam int MAX_KEYS_DEF     = 256;
   localparam int MAX_HEAD_DIM_DEF = 64;
   localparam int JOB_DEPTH        = 4;
   localparam int RSP_DEPTH        = 4;

   localparam logic [16:0] LOG2E_Q16 = 17'd94548;

   typedef enum logic [1:0] {
      CMD_KEY   = 2'd0,
      CMD_VALUE = 2'd1,
      CMD_QUERY = 2'd2
   } cah_cmd_type;

   typedef enum logic [1:0] {
      CSR_HEAD_DIM    = 2'd0,
      CSR_KEY_COUNT   = 2'd1,
      CSR_POS_OFFSET  = 2'd2,
      CSR_SCORE_SCALE = 2'd3
   } cah_csr_type;

   typedef enum logic [1:0] {
      KIND_KEY,
      KIND_VALUE,
      KIND_QUERY,
      KIND_QUERY_LAST
   } cah_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCORE,
      ST_SCORE_DRAIN,
      ST_EXP_RD,
      ST_EXP_SUB,
      ST_EXP_MUL,
      ST_EXP_INT,
      ST_EXP_WR,
      ST_DIV,
      ST_OUT_RD,
      ST_OUT_P,
      ST_OUT_MAC,
      ST_OUT_DRAIN,
      ST_EMIT_RD,
      ST_EMIT_WR
   } cah_state_type;

   typedef struct packed {
      cah_kind_type       kind;
      logic [11:0]        row;
      logic [5:0]         dim;
      logic signed [15:0] element;
      logic [8:0]         nk;
   } cah_item_type;

   typedef struct packed {
      logic [6:0]  head_dim;
      logic [15:0] scale;
   } cah_cfg_type;

   typedef struct packed {
      logic signed [15:0] out_element;
      logic [11:0]        out_row;
      logic [5:0]         out_dim;
      logic               last;
   } cah_rsp_type;

   // 2^-x at x = j/16
   function automatic logic [16:0] pow2_neg(input logic [4:0] j);
      logic [16:0] v;
      case (j)
         5'd0:    v = 17'd65536;
         5'd1:    v = 17'd62757;
         5'd2:    v = 17'd60097;
         5'd3:    v = 17'd57549;
         5'd4:    v = 17'd55109;
         5'd5:    v = 17'd52773;
         5'd6:    v = 17'd50535;
         5'd7:    v = 17'd48393;
         5'd8:    v = 17'd46341;
         5'd9:    v = 17'd44376;
         5'd10:   v = 17'd42495;
         5'd11:   v = 17'd40693;
         5'd12:   v = 17'd38968;
         5'd13:   v = 17'd37316;
         5'd14:   v = 17'd35734;
         5'd15:   v = 17'd34219;
         default: v = 17'd32768;
      endcase
      return v;
   endfunction

endpackage

[rtl/core/cah_fifo.sv]
module cah_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (32'(wr_ff) == DEPTH - 1) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (32'(rd_ff) == DEPTH - 1) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end
endmodule

[rtl/core/cah_front.sv]
module cah_front import cah_pkg::*; #(
   parameter int MAX_KEYS     = MAX_KEYS_DEF,
   parameter int MAX_HEAD_DIM = MAX_HEAD_DIM_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid,
   output logic               ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_cmd,
   input  logic [11:0]        req_row,
   input  logic [5:0]         req_dim,
   input  logic signed [15:0] req_element,
   input  logic               job_full,
   output logic               job_push,
   output cah_item_type       job_item,
   output cah_cfg_type        cfg
);
   logic [6:0]   head_dim_ff;
   logic [8:0]   key_count_ff;
   logic [15:0]  offset_ff;
   logic [15:0]  scale_ff;
   logic [6:0]   hd_eff;
   logic [8:0]   kc;
   logic [17:0]  limit;
   logic         kv_ok;
   logic         keep;
   cah_kind_type kind;

   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_dim_ff  <= 7'd64;
         key_count_ff <= 9'd256;
         offset_ff    <= 16'd0;
         scale_ff     <= 16'd8192;
      end else if (valid) begin
         case (cah_csr_type'(csr_index))
            CSR_HEAD_DIM:    head_dim_ff  <= csr_data[6:0];
            CSR_KEY_COUNT:   key_count_ff <= csr_data[8:0];
            CSR_POS_OFFSET:  offset_ff    <= csr_data;
            CSR_SCORE_SCALE: scale_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (head_dim_ff == '0) begin
         hd_eff = 7'd1;
      end else if (32'(head_dim_ff) > MAX_HEAD_DIM) begin
         hd_eff = 7'(MAX_HEAD_DIM);
      end else begin
         hd_eff = head_dim_ff;
      end
      if (32'(key_count_ff) > MAX_KEYS) begin
         kc = 9'(MAX_KEYS);
      end else begin
         kc = key_count_ff;
      end
   end

   // causal limit: keys up to the query's own sequence position
   assign limit = 18'(offset_ff) + 18'(req_row) + 18'd1;
   assign kv_ok = (32'(req_row) < MAX_KEYS) && (32'(req_dim) < MAX_HEAD_DIM);

   always_comb begin
      keep = 1'b0;
      kind = KIND_KEY;
      case (cah_cmd_type'(req_cmd))
         CMD_KEY: begin
            keep = kv_ok;
            kind = KIND_KEY;
         end
         CMD_VALUE: begin
            keep = kv_ok;
            kind = KIND_VALUE;
         end
         CMD_QUERY: begin
            keep = ({1'b0, req_dim} < hd_eff);
            kind = ({1'b0, req_dim} == hd_eff - 7'd1) ? KIND_QUERY_LAST : KIND_QUERY;
         end
         default: ;
      endcase
   end

   assign full             = job_full;
   assign job_push         = push && !job_full && keep;
   assign job_item.kind    = kind;
   assign job_item.row     = req_row;
   assign job_item.dim     = req_dim;
   assign job_item.element = req_element;
   assign job_item.nk      = (limit < 18'(kc)) ? 9'(limit) : kc;
   assign cfg.head_dim     = hd_eff;
   assign cfg.scale        = scale_ff;
endmodule

[rtl/core/cah_back.sv]
module cah_back import cah_pkg::*; #(
   parameter int MAX_KEYS     = MAX_KEYS_DEF,
   parameter int MAX_HEAD_DIM = MAX_HEAD_DIM_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  cah_cfg_type  cfg,
   input  logic         job_empty,
   input  cah_item_type job_item,
   output logic         job_pop,
   input  logic         rsp_full,
   output logic         rsp_push,
   output cah_rsp_type  rsp_item
);
   localparam int KIW    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int DIW    = (MAX_HEAD_DIM > 1) ? $clog2(MAX_HEAD_DIM) : 1;
   localparam int DOT_W  = 33 + DIW;
   localparam int SCL_W  = DOT_W + 17;
   localparam int SUM_W  = 18 + KIW;
   localparam int OACC_W = 35 + KIW;

   cah_state_type state_ff, state_in;

   logic signed [15:0] key_mem [MAX_KEYS][MAX_HEAD_DIM];
   logic signed [15:0] val_mem [MAX_KEYS][MAX_HEAD_DIM];
   logic signed [15:0] q_mem   [MAX_HEAD_DIM];
   logic [31:0]        sc_mem  [MAX_KEYS];
   logic [OACC_W-1:0]  acc_mem [MAX_HEAD_DIM];

   logic signed [15:0] key_rd_ff, val_rd_ff, q_rd_ff;
   logic [31:0]        sc_rd_ff;
   logic signed [OACC_W-1:0] acc_rd_ff;

   logic [KIW-1:0] k_ff;
   logic [DIW-1:0] i_ff;
   logic [KIW-1:0] wr_k;
   logic [DIW-1:0] wr_i;
   logic           i_last, k_last;

   logic [11:0]    row_ff;
   logic [8:0]     nk_ff;
   logic           zero_ff;

   // control strobes
   logic           key_we, val_we, q_we, job_start, score_issue, out_issue;
   logic           sc_we;
   logic [KIW-1:0] sc_addr;
   logic [31:0]    sc_wdata;

   // score pipeline
   logic                     s1_valid_ff, s1_first_ff, s1_last_ff;
   logic [KIW-1:0]           s1_k_ff;
   logic                     s2_valid_ff, s2_first_ff, s2_last_ff;
   logic [KIW-1:0]           s2_k_ff;
   logic signed [31:0]       prod_ff;
   logic                     s3_valid_ff;
   logic [KIW-1:0]           s3_k_ff;
   logic signed [DOT_W-1:0]  dacc_ff;
   logic                     s4_valid_ff;
   logic [KIW-1:0]           s4_k_ff;
   logic signed [SCL_W-1:0]  scl_ff;
   logic signed [SCL_W-1:0]  scl_sh;
   logic signed [31:0]       score;
   logic signed [31:0]       max_ff;

   // exponent and normalization
   logic [32:0]      d_ff;
   logic [33:0]      t_ff;
   logic [16:0]      e_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] rem_ff;
   logic [SUM_W:0]   trial;
   logic [16:0]      quo_ff;
   logic [5:0]       dcnt_ff;
   logic [17:0]      p_ff;

   // output pipeline
   logic                     oa_valid_ff, oa_first_ff;
   logic [DIW-1:0]           oa_i_ff;
   logic                     ob_valid_ff, ob_first_ff;
   logic [DIW-1:0]           ob_i_ff;
   logic signed [34:0]       oprod_ff;
   logic                     acc_we;
   logic [OACC_W-1:0]        acc_wdata;
   logic [DIW-1:0]           acc_raddr;
   logic signed [OACC_W-1:0] r_sum, r_sh;
   logic signed [15:0]       out_val;

   function automatic logic [16:0] exp_interp(input logic [33:0] t);
      logic [17:0] n;
      logic [3:0]  j;
      logic [11:0] r;
      logic [16:0] a, b, v;
      logic [28:0] m;
      n = t[33:16];
      j = t[15:12];
      r = t[11:0];
      a = pow2_neg({1'b0, j});
      b = pow2_neg({1'b0, j} + 5'd1);
      m = 29'(a - b) * 29'(r);
      v = a - 17'(m >> 12);
      if (n >= 18'd17) begin
         return '0;
      end
      return v >> n[4:0];
   endfunction

   assign i_last = (32'(i_ff) + 32'd1 == 32'(cfg.head_dim));
   assign k_last = (32'(k_ff) + 32'd1 == 32'(nk_ff));
   assign wr_k   = KIW'(job_item.row);
   assign wr_i   = DIW'(job_item.dim);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty && job_item.kind == KIND_QUERY_LAST) begin
               state_in = (job_item.nk == '0) ? ST_EMIT_RD : ST_SCORE;
            end
         end
         ST_SCORE: begin
            if (i_last && k_last) begin
               state_in = ST_SCORE_DRAIN;
            end
         end
         ST_SCORE_DRAIN: begin
            if (!s1_valid_ff && !s2_valid_ff && !s3_valid_ff && !s4_valid_ff) begin
               state_in = ST_EXP_RD;
            end
         end
         ST_EXP_RD:  state_in = ST_EXP_SUB;
         ST_EXP_SUB: state_in = ST_EXP_MUL;
         ST_EXP_MUL: state_in = ST_EXP_INT;
         ST_EXP_INT: state_in = ST_EXP_WR;
         ST_EXP_WR:  state_in = k_last ? ST_DIV : ST_EXP_RD;
         ST_DIV: begin
            if (dcnt_ff == '0) begin
               state_in = ST_OUT_RD;
            end
         end
         ST_OUT_RD:  state_in = ST_OUT_P;
         ST_OUT_P:   state_in = ST_OUT_MAC;
         ST_OUT_MAC: begin
            if (i_last) begin
               state_in = k_last ? ST_OUT_DRAIN : ST_OUT_RD;
            end
         end
         ST_OUT_DRAIN: begin
            if (!oa_valid_ff && !ob_valid_ff) begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            if (!rsp_full) begin
               state_in = ST_EMIT_WR;
            end
         end
         ST_EMIT_WR: state_in = i_last ? ST_IDLE : ST_EMIT_RD;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      job_pop     = 1'b0;
      key_we      = 1'b0;
      val_we      = 1'b0;
      q_we        = 1'b0;
      job_start   = 1'b0;
      score_issue = 1'b0;
      out_issue   = 1'b0;
      rsp_push    = 1'b0;
      sc_we       = s4_valid_ff;
      sc_addr     = s4_valid_ff ? s4_k_ff : k_ff;
      sc_wdata    = score;
      acc_raddr   = oa_i_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               case (job_item.kind)
                  KIND_KEY:   key_we = 1'b1;
                  KIND_VALUE: val_we = 1'b1;
                  KIND_QUERY: q_we   = 1'b1;
                  KIND_QUERY_LAST: begin
                     q_we      = 1'b1;
                     job_start = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCORE:   score_issue = 1'b1;
         ST_EXP_WR: begin
            sc_we    = 1'b1;
            sc_wdata = 32'(e_ff);
         end
         ST_OUT_MAC: out_issue = 1'b1;
         ST_EMIT_RD: acc_raddr = i_ff;
         ST_EMIT_WR: begin
            acc_raddr = i_ff;
            rsp_push  = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // stores
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[wr_k][wr_i] <= job_item.element;
      end
      key_rd_ff <= key_mem[k_ff][i_ff];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[wr_k][wr_i] <= job_item.element;
      end
      val_rd_ff <= val_mem[k_ff][i_ff];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[wr_i] <= job_item.element;
      end
      q_rd_ff <= q_mem[i_ff];
   end

   always_ff @(posedge clock) begin
      if (sc_we) begin
         sc_mem[sc_addr] <= sc_wdata;
      end
      sc_rd_ff <= sc_mem[sc_addr];
   end

   // forward a write to the same entry so a one-element row reads fresh data
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[ob_i_ff] <= acc_wdata;
      end
      if (acc_we && ob_i_ff == acc_raddr) begin
         acc_rd_ff <= acc_wdata;
      end else begin
         acc_rd_ff <= acc_mem[acc_raddr];
      end
   end

   // counters and job registers
   always_ff @(posedge clock) begin
      if (job_start) begin
         row_ff  <= job_item.row;
         nk_ff   <= job_item.nk;
         zero_ff <= (job_item.nk == '0);
      end
      case (state_ff)
         ST_IDLE: begin
            k_ff <= '0;
            i_ff <= '0;
         end
         ST_SCORE, ST_OUT_MAC: begin
            if (i_last) begin
               i_ff <= '0;
               if (!k_last) begin
                  k_ff <= k_ff + 1'b1;
               end
            end else begin
               i_ff <= i_ff + 1'b1;
            end
         end
         ST_SCORE_DRAIN, ST_DIV: k_ff <= '0;
         ST_EXP_WR: begin
            if (!k_last) begin
               k_ff <= k_ff + 1'b1;
            end
         end
         ST_OUT_DRAIN: i_ff <= '0;
         ST_EMIT_WR: i_ff <= i_ff + 1'b1;
         default: ;
      endcase
   end

   // score pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= score_issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff && s2_last_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   assign scl_sh = scl_ff >>> 16;

   always_comb begin
      if (scl_sh > $signed(SCL_W'(32'h7FFF_FFFF))) begin
         score = 32'sh7FFF_FFFF;
      end else if (scl_sh < $signed({{(SCL_W - 32){1'b1}}, 32'h8000_0000})) begin
         score = 32'sh8000_0000;
      end else begin
         score = scl_sh[31:0];
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= (i_ff == '0);
      s1_last_ff  <= i_last;
      s1_k_ff     <= k_ff;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_k_ff     <= s1_k_ff;
      prod_ff     <= q_rd_ff * key_rd_ff;
      if (s2_valid_ff) begin
         dacc_ff <= s2_first_ff ? DOT_W'(prod_ff) : dacc_ff + DOT_W'(prod_ff);
      end
      s3_k_ff <= s2_k_ff;
      scl_ff  <= dacc_ff * $signed({1'b0, cfg.scale});
      s4_k_ff <= s3_k_ff;
      if (job_start) begin
         max_ff <= 32'sh8000_0000;
      end else if (s4_valid_ff && score > max_ff) begin
         max_ff <= score;
      end
   end

   // exponent, sum and reciprocal
   assign trial = {rem_ff, (dcnt_ff == 6'd32)};

   always_ff @(posedge clock) begin
      d_ff <= 33'($signed({max_ff[31], max_ff}) - $signed({sc_rd_ff[31], sc_rd_ff}));
      t_ff <= 34'((50'(d_ff) * 50'(LOG2E_Q16)) >> 16);
      e_ff <= exp_interp(t_ff);
      if (job_start) begin
         sum_ff <= '0;
      end else if (state_ff == ST_EXP_WR) begin
         sum_ff <= sum_ff + SUM_W'(e_ff);
      end
      if (state_ff == ST_EXP_WR) begin
         rem_ff  <= '0;
         quo_ff  <= '0;
         dcnt_ff <= 6'd32;
      end else if (state_ff == ST_DIV) begin
         dcnt_ff <= dcnt_ff - 1'b1;
         if (trial >= {1'b0, sum_ff}) begin
            rem_ff <= SUM_W'(trial - {1'b0, sum_ff});
            quo_ff <= {quo_ff[15:0], 1'b1};
         end else begin
            rem_ff <= trial[SUM_W-1:0];
            quo_ff <= {quo_ff[15:0], 1'b0};
         end
      end
      if (state_ff == ST_OUT_P) begin
         p_ff <= 18'((34'(sc_rd_ff[16:0]) * 34'(quo_ff)) >> 16);
      end
   end

   // weighted value sums
   always_ff @(posedge clock) begin
      if (reset) begin
         oa_valid_ff <= 1'b0;
         ob_valid_ff <= 1'b0;
      end else begin
         oa_valid_ff <= out_issue;
         ob_valid_ff <= oa_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      oa_i_ff     <= i_ff;
      oa_first_ff <= (k_ff == '0);
      ob_i_ff     <= oa_i_ff;
      ob_first_ff <= oa_first_ff;
      oprod_ff    <= $signed({1'b0, p_ff}) * val_rd_ff;
   end

   assign acc_we    = ob_valid_ff;
   assign acc_wdata = (ob_first_ff ? '0 : acc_rd_ff) + OACC_W'(oprod_ff);

   // round half up, then saturate to Q8.8
   always_comb begin
      r_sum = acc_rd_ff + $signed(OACC_W'(32768));
      r_sh  = r_sum >>> 16;
      if (zero_ff) begin
         out_val = '0;
      end else if (r_sh > $signed(OACC_W'(32767))) begin
         out_val = 16'sh7FFF;
      end else if (r_sh < -$signed(OACC_W'(32768))) begin
         out_val = 16'sh8000;
      end else begin
         out_val = r_sh[15:0];
      end
   end

   assign rsp_item.out_element = out_val;
   assign rsp_item.out_row     = row_ff;
   assign rsp_item.out_dim     = 6'(i_ff);
   assign rsp_item.last        = i_last;
endmodule

[rtl/core/causal_attention_head_unit.sv]
// Channel   Ports                                           Moves a word when
// --------  ----------------------------------------------  ---------------------
// request   push full req_cmd req_row req_dim req_element   push && !full
// response  empty pop rsp_out_element rsp_out_row           pop && !empty
//           rsp_out_dim rsp_last
// csr       valid ready csr_index csr_data                  valid && ready
//
// Key, value and non-final query words are written to their stores as the back end pops them while idle.
// A word that completes a query row runs the score loop over the key store, the
// exponent and divide steps, the multiply-accumulate loop over the value store
// and the emit loop; a row with no keys goes straight to the emit loop.
// Reset clears control only; stores hold garbage until written.
// A full response queue stalls the emit loop; a full job queue stalls requests.
module causal_attention_head_unit import cah_pkg::*; #(
   parameter int MAX_KEYS     = MAX_KEYS_DEF,
   parameter int MAX_HEAD_DIM = MAX_HEAD_DIM_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_cmd,
   input  logic [11:0]        req_row,
   input  logic [5:0]         req_dim,
   input  logic signed [15:0] req_element,
   output logic               empty,
   input  logic               pop,
   output logic signed [15:0] rsp_out_element,
   output logic [11:0]        rsp_out_row,
   output logic [5:0]         rsp_out_dim,
   output logic               rsp_last,
   input  logic               valid,
   output logic               ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   cah_item_type job_wr, job_rd;
   cah_cfg_type  cfg;
   cah_rsp_type  rsp_wr, rsp_rd;
   logic         job_push, job_full, job_pop, job_empty;
   logic         rsp_push, rsp_full;

   cah_front #(.MAX_KEYS(MAX_KEYS), .MAX_HEAD_DIM(MAX_HEAD_DIM)) u_front (
      .clock, .reset, .valid, .ready, .csr_index, .csr_data,
      .push, .full, .req_cmd, .req_row, .req_dim, .req_element,
      .job_full, .job_push, .job_item(job_wr), .cfg
   );

   cah_fifo #(.WIDTH($bits(cah_item_type)), .DEPTH(JOB_DEPTH)) u_job_q (
      .clock, .reset, .push(job_push), .wdata(job_wr), .full(job_full),
      .pop(job_pop), .rdata(job_rd), .empty(job_empty)
   );

   cah_back #(.MAX_KEYS(MAX_KEYS), .MAX_HEAD_DIM(MAX_HEAD_DIM)) u_back (
      .clock, .reset, .cfg, .job_empty, .job_item(job_rd), .job_pop,
      .rsp_full, .rsp_push, .rsp_item(rsp_wr)
   );

   cah_fifo #(.WIDTH($bits(cah_rsp_type)), .DEPTH(RSP_DEPTH)) u_rsp_q (
      .clock, .reset, .push(rsp_push), .wdata(rsp_wr), .full(rsp_full),
      .pop, .rdata(rsp_rd), .empty
   );

   assign rsp_out_element = rsp_rd.out_element;
   assign rsp_out_row     = rsp_rd.out_row;
   assign rsp_out_dim     = rsp_rd.out_dim;
   assign rsp_last        = rsp_rd.last;
endmodule
